>>> hw/rtl/acrms_pkg.sv
// Shared types and constants for the AC RMS meter with DC tracking.
package acrms_pkg;

  // Fixed field and register widths.
  localparam int SUM_BITS   = 48;
  localparam int ROOT_BITS  = SUM_BITS / 2;
  localparam int CFG_BITS   = 16;
  localparam int IDX_BITS   = 2;
  localparam int WL_BITS    = 10;
  localparam int GAIN_BITS  = 16;
  localparam int SCALE_BITS = 16;
  localparam int LEVEL_BITS = 16;
  localparam int RMS_BITS   = 8;

  // Configuration register indexes.
  localparam logic [IDX_BITS-1:0] REG_WINDOW_LENGTH = 2'd0;
  localparam logic [IDX_BITS-1:0] REG_OFFSET_GAIN   = 2'd1;
  localparam logic [IDX_BITS-1:0] REG_RMS_SCALE     = 2'd2;

  // Register reset values.
  localparam logic [WL_BITS-1:0]    WINDOW_LENGTH_RESET = 10'd100;
  localparam logic [GAIN_BITS-1:0]  OFFSET_GAIN_RESET   = 16'd328;
  localparam logic [SCALE_BITS-1:0] RMS_SCALE_RESET     = 16'd5561;

  // The offset starts at 1650 mV, which needs at least 11 integer bits.
  localparam int OFFSET_RESET_MV = 1650;
  localparam int OFFSET_MIN_INT  = 11;

  // One closed window handed from the front end to the back end.
  typedef struct packed {
    logic [SUM_BITS-1:0]   sum;
    logic [WL_BITS-1:0]    divisor;
    logic [LEVEL_BITS-1:0] level;
  } acrms_window_t;

endpackage

>>> hw/rtl/ac_rms_meter_dc_tracking.sv
// Top level of the AC RMS meter with DC tracking.
// Each request on the input carries one converter sample in millivolts. The front end takes one
// sample per clock: it updates the DC offset filter, squares the sample's deviation from the
// offset into the b stage register, then adds the square to the window sum. When a window
// closes, its sum and offset move through a two-entry queue to the back end, which divides by the
// window length, takes the square root and applies the scale multiply, then offers the result. It
// takes a new window only after its last result has been taken. The input stalls only when two
// closed windows are already waiting, which takes windows that close faster than the back end
// finishes them or a result side that holds off. No clearing pass follows reset; configuration
// writes take effect at once and belong to idle periods.
module ac_rms_meter_dc_tracking import acrms_pkg::*; #(
  parameter int SAMPLE_BITS = 12,
  parameter int COUNT_BITS  = 10
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [SAMPLE_BITS-1:0] sample_mv,
  input  logic                   in_valid,
  output logic                   in_ready,
  output logic [RMS_BITS-1:0]    rms_volts,
  output logic [LEVEL_BITS-1:0]  offset_level,
  output logic                   rms_saturated,
  output logic                   out_valid,
  input  logic                   out_ready,
  input  logic                   cfg_write,
  input  logic [IDX_BITS-1:0]    cfg_index,
  input  logic [CFG_BITS-1:0]    cfg_data
);

  logic [WL_BITS-1:0]    window_length;
  logic [GAIN_BITS-1:0]  offset_gain;
  logic [SCALE_BITS-1:0] rms_scale;

  acrms_window_t front_win;
  logic          front_valid;
  logic          front_ready;
  acrms_window_t back_win;
  logic          back_valid;
  logic          back_ready;

  // Configuration registers; writes to unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      window_length <= WINDOW_LENGTH_RESET;
      offset_gain   <= OFFSET_GAIN_RESET;
      rms_scale     <= RMS_SCALE_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_WINDOW_LENGTH: window_length <= cfg_data[WL_BITS-1:0];
        REG_OFFSET_GAIN:   offset_gain   <= cfg_data[GAIN_BITS-1:0];
        REG_RMS_SCALE:     rms_scale     <= cfg_data[SCALE_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  acrms_front #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .COUNT_BITS  (COUNT_BITS)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .sample_mv     (sample_mv),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .window_length (window_length),
    .offset_gain   (offset_gain),
    .win           (front_win),
    .win_valid     (front_valid),
    .win_ready     (front_ready)
  );

  acrms_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_data  (front_win),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .pop_data   (back_win),
    .pop_valid  (back_valid),
    .pop_ready  (back_ready)
  );

  acrms_back u_back (
    .clk           (clk),
    .rst           (rst),
    .win           (back_win),
    .win_valid     (back_valid),
    .win_ready     (back_ready),
    .rms_scale     (rms_scale),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .rms_volts     (rms_volts),
    .offset_level  (offset_level),
    .rms_saturated (rms_saturated)
  );

endmodule

>>> hw/rtl/acrms_front.sv
// Front end: DC tracking filter, deviation square and window accumulator.
module acrms_front import acrms_pkg::*; #(
  parameter int SAMPLE_BITS = 12,
  parameter int COUNT_BITS  = 10
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [SAMPLE_BITS-1:0] sample_mv,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [WL_BITS-1:0]     window_length,
  input  logic [GAIN_BITS-1:0]   offset_gain,
  output acrms_window_t          win,
  output logic                   win_valid,
  input  logic                   win_ready
);

  localparam int OFS_INT  = (SAMPLE_BITS > OFFSET_MIN_INT) ? SAMPLE_BITS : OFFSET_MIN_INT;
  localparam int OFS_BITS = OFS_INT + 16;
  localparam int MAG_BITS = OFS_BITS - 12;
  localparam int DEV_BITS = MAG_BITS + 1;
  localparam int SQ_BITS  = 2 * MAG_BITS;
  localparam int CMP_BITS = (COUNT_BITS > WL_BITS) ? COUNT_BITS : WL_BITS;
  localparam logic [OFS_BITS-1:0] OFFSET_RESET = OFS_BITS'(OFFSET_RESET_MV) << 16;

  logic [OFS_BITS-1:0]          offset;
  logic signed [OFS_BITS:0]     iir_diff;
  logic signed [OFS_BITS+17:0]  iir_prod;
  logic signed [OFS_BITS+17:0]  iir_step;
  logic [OFS_BITS-1:0]          offset_next;

  logic                   a_valid;
  logic [SAMPLE_BITS-1:0] a_sample;
  logic [MAG_BITS-1:0]    a_level;

  logic signed [DEV_BITS-1:0] dev;
  logic [MAG_BITS-1:0]        mag;

  logic                  b_valid;
  logic [SQ_BITS-1:0]    b_sq;
  logic [LEVEL_BITS-1:0] b_level;

  logic [SUM_BITS-1:0]   sum;
  logic [SUM_BITS:0]     sum_add;
  logic [COUNT_BITS-1:0] count;
  logic                  close;
  logic                  advance;
  logic                  accept;

  // Truncating IIR update, rewritten as offset + g*(sample - offset).
  assign iir_diff    = $signed((OFS_BITS+1)'({sample_mv, 16'd0})) - $signed({1'b0, offset});
  assign iir_prod    = $signed({1'b0, offset_gain}) * iir_diff;
  assign iir_step    = iir_prod >>> 16;
  assign offset_next = offset + iir_step[OFS_BITS-1:0];

  // Deviation of the sample from the tracked level, in Q.4.
  assign dev = $signed(DEV_BITS'({a_sample, 4'd0})) - $signed(DEV_BITS'(a_level));
  assign mag = dev[DEV_BITS-1] ? MAG_BITS'(-dev) : MAG_BITS'(dev);

  // Window close check and the stall it causes when the queue is full.
  assign close    = CMP_BITS'(count) >= CMP_BITS'(window_length);
  assign advance  = !(b_valid && close && !win_ready);
  assign in_ready = advance;
  assign accept   = in_valid && advance;
  assign sum_add  = {1'b0, sum} + (SUM_BITS+1)'(b_sq);

  // Closed window request toward the queue.
  assign win_valid   = b_valid && close;
  assign win.sum     = sum;
  assign win.divisor = (window_length == '0) ? WL_BITS'(1) : window_length;
  assign win.level   = b_level;

  // Filter state and pipeline valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      offset  <= OFFSET_RESET;
      a_valid <= 1'b0;
      b_valid <= 1'b0;
    end else begin
      if (accept) begin
        offset <= offset_next;
      end
      if (advance) begin
        a_valid <= in_valid;
        b_valid <= a_valid;
      end
    end
  end

  // Pipeline payload.
  always_ff @(posedge clk) begin
    if (advance) begin
      a_sample <= sample_mv;
      a_level  <= offset_next[OFS_BITS-1:12];
      b_sq     <= mag * mag;
      b_level  <= LEVEL_BITS'(a_level);
    end
  end

  // Saturating square accumulator and sample counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      sum   <= '0;
      count <= '0;
    end else if (b_valid && advance) begin
      if (close) begin
        sum   <= SUM_BITS'(b_sq);
        count <= COUNT_BITS'(1);
      end else begin
        sum   <= sum_add[SUM_BITS] ? {SUM_BITS{1'b1}} : sum_add[SUM_BITS-1:0];
        count <= count + COUNT_BITS'(1);
      end
    end
  end

`ifndef SYNTHESIS
  // Accumulation within a window never makes the sum smaller.
  assert property (@(posedge clk) disable iff (rst)
    (b_valid && advance && !close) |=> (sum >= $past(sum)))
    else $error("square sum decreased within a window");
`endif

endmodule

>>> hw/rtl/acrms_queue.sv
// Two-entry queue of closed windows between the front and back ends.
module acrms_queue import acrms_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  acrms_window_t push_data,
  input  logic          push_valid,
  output logic          push_ready,
  output acrms_window_t pop_data,
  output logic          pop_valid,
  input  logic          pop_ready
);

  localparam int DEPTH     = 2;
  localparam int PTR_BITS  = $clog2(DEPTH);
  localparam int CNT_BITS  = $clog2(DEPTH + 1);

  acrms_window_t         slots [DEPTH];
  logic [PTR_BITS-1:0]   wr_ptr;
  logic [PTR_BITS-1:0]   rd_ptr;
  logic [CNT_BITS-1:0]   count;
  logic                  push;
  logic                  pop;

  assign push_ready = count != CNT_BITS'(DEPTH);
  assign pop_valid  = count != '0;
  assign pop_data   = slots[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PTR_BITS'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_BITS'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_BITS'(1);
      end else if (pop && !push) begin
        count <= count - CNT_BITS'(1);
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

`ifndef SYNTHESIS
  // A lone push grows the fill count by exactly one.
  assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count == $past(count) + CNT_BITS'(1)))
    else $error("queue count did not follow a push");
  // The write pointer leads the read pointer by the fill count.
  assert property (@(posedge clk) disable iff (rst)
    (wr_ptr - rd_ptr) == PTR_BITS'(count))
    else $error("queue pointers disagree with count");
`endif

endmodule

>>> hw/rtl/acrms_back.sv
// Back end: window mean by restoring division, integer root and output scaling.
module acrms_back import acrms_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  acrms_window_t         win,
  input  logic                  win_valid,
  output logic                  win_ready,
  input  logic [SCALE_BITS-1:0] rms_scale,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [RMS_BITS-1:0]   rms_volts,
  output logic [LEVEL_BITS-1:0] offset_level,
  output logic                  rms_saturated
);

  localparam int STEP_BITS = $clog2(SUM_BITS);
  localparam int PROD_BITS = ROOT_BITS + SCALE_BITS;
  localparam int SCL_BITS  = PROD_BITS - 16;

  typedef enum logic [2:0] {
    IDLE,
    DIVIDE,
    ROOT,
    SCALE,
    HOLD
  } state_t;

  state_t                state;
  logic [STEP_BITS-1:0]  step;
  logic [SUM_BITS-1:0]   work;
  logic [WL_BITS-1:0]    divisor;
  logic [WL_BITS-1:0]    div_rem;
  logic [ROOT_BITS+1:0]  root_rem;
  logic [ROOT_BITS-1:0]  root;
  logic [PROD_BITS-1:0]  prod;

  logic [WL_BITS:0]      div_shift;
  logic                  div_fits;
  logic [ROOT_BITS+1:0]  rt_shift;
  logic [ROOT_BITS+1:0]  rt_trial;
  logic                  rt_fits;
  logic [SCL_BITS-1:0]   scaled;

  // One restoring division step: bring down the next dividend bit.
  assign div_shift = {div_rem, work[SUM_BITS-1]};
  assign div_fits  = div_shift >= {1'b0, divisor};

  // One square-root step: bring down the next two radicand bits.
  assign rt_shift = {root_rem[ROOT_BITS-1:0], work[SUM_BITS-1:SUM_BITS-2]};
  assign rt_trial = {root, 2'b01};
  assign rt_fits  = rt_shift >= rt_trial;

  // Output clipping from the registered product.
  assign scaled        = prod[PROD_BITS-1:16];
  assign rms_saturated = scaled > SCL_BITS'(255);
  assign rms_volts     = rms_saturated ? {RMS_BITS{1'b1}} : scaled[RMS_BITS-1:0];
  assign win_ready     = state == IDLE;

  // Sequencer with the datapath registers it steps through.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      out_valid <= 1'b0;
      step      <= '0;
    end else begin
      case (state)
        IDLE: begin
          if (win_valid) begin
            work         <= win.sum;
            divisor      <= win.divisor;
            offset_level <= win.level;
            div_rem      <= '0;
            step         <= '0;
            state        <= DIVIDE;
          end
        end
        DIVIDE: begin
          div_rem <= div_fits ? WL_BITS'(div_shift - {1'b0, divisor})
                              : div_shift[WL_BITS-1:0];
          work    <= {work[SUM_BITS-2:0], div_fits};
          if (step == STEP_BITS'(SUM_BITS - 1)) begin
            step     <= '0;
            root_rem <= '0;
            root     <= '0;
            state    <= ROOT;
          end else begin
            step <= step + STEP_BITS'(1);
          end
        end
        ROOT: begin
          root_rem <= rt_fits ? rt_shift - rt_trial : rt_shift;
          root     <= {root[ROOT_BITS-2:0], rt_fits};
          work     <= {work[SUM_BITS-3:0], 2'b00};
          if (step == STEP_BITS'(ROOT_BITS - 1)) begin
            step  <= '0;
            state <= SCALE;
          end else begin
            step <= step + STEP_BITS'(1);
          end
        end
        SCALE: begin
          prod      <= root * rms_scale;
          out_valid <= 1'b1;
          state     <= HOLD;
        end
        HOLD: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            state     <= IDLE;
          end
        end
        default: begin
          out_valid <= 1'b0;
          state     <= IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  // The partial remainder of the division stays below the divisor.
  assert property (@(posedge clk) disable iff (rst)
    (state == DIVIDE) |-> (div_rem < divisor))
    else $error("division remainder out of range");
  // The root remainder never exceeds twice the partial root.
  assert property (@(posedge clk) disable iff (rst)
    (state == ROOT) |-> (root_rem <= {1'b0, root, 1'b0}))
    else $error("root remainder out of range");
`endif

endmodule
